FILE: sv/bfst_pkg.sv
// ----------------------------------------------------------------------------
// Byte frequency sorted table package
// Shared constants, types and key ordering for the sorted byte histogram.
// ----------------------------------------------------------------------------
package bfst_pkg;

   // Table geometry
   localparam int COUNT_WIDTH  = 32;
   localparam int SYMBOL_COUNT = 256;
   localparam int INDEX_WIDTH  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

   // Port field widths
   localparam int OP_WIDTH        = 2;
   localparam int SYMBOL_WIDTH    = 8;
   localparam int OUT_COUNT_WIDTH = 32;

   // Operation codes
   localparam logic [OP_WIDTH-1:0] OP_COUNT = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_READ  = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_CLEAR = 2'd2;

   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [INDEX_WIDTH-1:0]  index_type;
   typedef logic [SYMBOL_WIDTH-1:0] symbol_type;

   // One past the last table index, for the scan counter
   localparam logic [INDEX_WIDTH:0] SCAN_END  = (INDEX_WIDTH+1)'(SYMBOL_COUNT);
   localparam count_type            COUNT_MAX = '1;

   // True when key (ca, sa) comes after key (cb, sb): ascending count,
   // higher symbol first among equal counts
   function automatic logic key_after(count_type ca, index_type sa,
                                      count_type cb, index_type sb);
      logic result;
      if (ca != cb) begin
         result = (ca > cb);
      end else begin
         result = (sa < sb);
      end
      return result;
   endfunction

   // Tab, line feed, vertical tab, form feed, carriage return and space
   function automatic logic is_space(symbol_type b);
      return ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20);
   endfunction

endpackage

FILE: sv/bfst_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/byte_frequency_sorted_table.sv
// ----------------------------------------------------------------------------
// Byte frequency sorted table
// Counts bytes into a table of saturating counters and reads the table back
// one entry at a time in ascending count order, higher symbol first on ties.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_operation and req_symbol with start high; the
//   transaction is taken at a clock edge where busy is low. Every request
//   yields exactly one response, shown for one cycle with rsp_strobe high.
//   Count: a RAM read then a write-back; a whitespace byte is
//   skipped and answered from idle without a RAM access.
//   Clear and the unused code answer from idle; clear drops all table entries
//   at once through per-entry valid flags and restarts the read order.
//   Read: a single compare unit walks the count RAM one entry per cycle,
//   keeping the smallest key above the one returned last.
//   busy stays high while a transaction is in progress; a new request may be
//   issued in the cycle its response is shown.
//   The receiver cannot stall; a response is lost if not taken in its cycle.
//   Reset empties the table and the read order, with no clearing pass.
// ----------------------------------------------------------------------------
module byte_frequency_sorted_table
   import bfst_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [OP_WIDTH-1:0]        req_operation,
   input  logic [SYMBOL_WIDTH-1:0]    req_symbol,
   output logic                       rsp_strobe,
   output logic                       rsp_valid_res,
   output logic [SYMBOL_WIDTH-1:0]    rsp_entry_symbol,
   output logic [OUT_COUNT_WIDTH-1:0] rsp_entry_count,
   output logic                       rsp_last_entry
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_COUNT = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;

   logic [1:0]              state_ff, state_in;
   index_type               sym_ff, sym_in;
   logic [INDEX_WIDTH:0]    scan_ff, scan_in;
   logic                    data_vld_ff, data_vld_in;
   index_type               data_idx_ff, data_idx_in;
   logic                    found_ff, found_in;
   logic                    more_ff, more_in;
   count_type               best_count_ff, best_count_in;
   index_type               best_sym_ff, best_sym_in;
   count_type               prev_count_ff, prev_count_in;
   index_type               prev_sym_ff, prev_sym_in;
   logic                    started_ff, started_in;
   logic [SYMBOL_COUNT-1:0] valid_ff, valid_in;
   logic                    strobe_ff, strobe_in;
   logic                    res_valid_ff, res_valid_in;
   symbol_type              res_sym_ff, res_sym_in;
   count_type               res_count_ff, res_count_in;
   logic                    res_last_ff, res_last_in;

   logic      ram_wr_en;
   index_type ram_wr_addr;
   count_type ram_wr_data;
   logic      ram_rd_en;
   index_type ram_rd_addr;
   count_type ram_rd_data;

   logic      accept;
   logic      sym_ok;
   logic      scan_issue;
   logic      scan_done;
   count_type elem_count;
   logic      elem_cand;
   logic      elem_better;
   count_type cur_count;

   assign accept     = start && (state_ff == ST_IDLE);
   assign sym_ok     = !is_space(req_symbol) &&
                       ({1'b0, req_symbol} < (SYMBOL_WIDTH+1)'(SYMBOL_COUNT));
   assign scan_issue = (state_ff == ST_SCAN) && (scan_ff < SCAN_END);
   assign scan_done  = (state_ff == ST_SCAN) && (scan_ff == SCAN_END) && !data_vld_ff;

   // Count value of the entry under compare; invalid entries read as zero
   assign elem_count  = valid_ff[data_idx_ff] ? ram_rd_data : '0;
   assign elem_cand   = data_vld_ff && (elem_count != '0) &&
                        (!started_ff ||
                         key_after(elem_count, data_idx_ff, prev_count_ff, prev_sym_ff));
   assign elem_better = !found_ff ||
                        key_after(best_count_ff, best_sym_ff, elem_count, data_idx_ff);

   assign cur_count   = valid_ff[sym_ff] ? ram_rd_data : '0;

   // RAM ports
   assign ram_rd_en   = (accept && (req_operation == OP_COUNT) && sym_ok) || scan_issue;
   assign ram_rd_addr = (state_ff == ST_SCAN) ? scan_ff[INDEX_WIDTH-1:0]
                                              : req_symbol[INDEX_WIDTH-1:0];
   assign ram_wr_en   = (state_ff == ST_COUNT) && (cur_count != COUNT_MAX);
   assign ram_wr_addr = sym_ff;
   assign ram_wr_data = cur_count + count_type'(1);

   bfst_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (SYMBOL_COUNT)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer and compare unit
   always_comb begin
      state_in      = state_ff;
      sym_in        = sym_ff;
      scan_in       = scan_ff;
      data_vld_in   = 1'b0;
      data_idx_in   = data_idx_ff;
      found_in      = found_ff;
      more_in       = more_ff;
      best_count_in = best_count_ff;
      best_sym_in   = best_sym_ff;
      prev_count_in = prev_count_ff;
      prev_sym_in   = prev_sym_ff;
      started_in    = started_ff;
      valid_in      = valid_ff;
      strobe_in     = 1'b0;
      res_valid_in  = 1'b0;
      res_sym_in    = '0;
      res_count_in  = '0;
      res_last_in   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  OP_COUNT: begin
                     // Skip whitespace with an immediate empty response
                     if (sym_ok) begin
                        sym_in   = req_symbol[INDEX_WIDTH-1:0];
                        state_in = ST_COUNT;
                     end else begin
                        strobe_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     scan_in  = '0;
                     found_in = 1'b0;
                     more_in  = 1'b0;
                     state_in = ST_SCAN;
                  end
                  OP_CLEAR: begin
                     valid_in      = '0;
                     prev_count_in = '0;
                     prev_sym_in   = '0;
                     started_in    = 1'b0;
                     strobe_in     = 1'b1;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_COUNT: begin
            // Write back the incremented count, hold at the top value
            if (cur_count != COUNT_MAX) begin
               valid_in[sym_ff] = 1'b1;
            end
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SCAN: begin
            // Advance the read address
            if (scan_issue) begin
               scan_in     = scan_ff + 1'b1;
               data_vld_in = 1'b1;
               data_idx_in = scan_ff[INDEX_WIDTH-1:0];
            end
            // Keep the smallest candidate; two candidates mean more follow
            if (elem_cand) begin
               if (found_ff) begin
                  more_in = 1'b1;
               end
               if (elem_better) begin
                  best_count_in = elem_count;
                  best_sym_in   = data_idx_ff;
               end
               found_in = 1'b1;
            end
            if (scan_done) begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
               if (found_ff) begin
                  prev_count_in = best_count_ff;
                  prev_sym_in   = best_sym_ff;
                  started_in    = 1'b1;
                  res_valid_in  = 1'b1;
                  res_sym_in    = SYMBOL_WIDTH'(best_sym_ff);
                  res_count_in  = best_count_ff;
                  res_last_in   = !more_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         data_vld_ff   <= 1'b0;
         started_ff    <= 1'b0;
         prev_count_ff <= '0;
         prev_sym_ff   <= '0;
         valid_ff      <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         data_vld_ff   <= data_vld_in;
         started_ff    <= started_in;
         prev_count_ff <= prev_count_in;
         prev_sym_ff   <= prev_sym_in;
         valid_ff      <= valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      scan_ff       <= scan_in;
      data_idx_ff   <= data_idx_in;
      found_ff      <= found_in;
      more_ff       <= more_in;
      best_count_ff <= best_count_in;
      best_sym_ff   <= best_sym_in;
      res_valid_ff  <= res_valid_in;
      res_sym_ff    <= res_sym_in;
      res_count_ff  <= res_count_in;
      res_last_ff   <= res_last_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_valid_res    = res_valid_ff;
   assign rsp_entry_symbol = res_sym_ff;
   assign rsp_entry_count  = OUT_COUNT_WIDTH'(res_count_ff);
   assign rsp_last_entry   = res_last_ff;

endmodule

FILE: sv/bfst_checker.sv
// ----------------------------------------------------------------------------
// Byte frequency sorted table checker
// Port-level properties of the request and response channels.
// ----------------------------------------------------------------------------
module bfst_checker
   import bfst_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic [OP_WIDTH-1:0]        req_operation,
   input logic                       rsp_strobe,
   input logic                       rsp_valid_res,
   input logic [SYMBOL_WIDTH-1:0]    rsp_entry_symbol,
   input logic [OUT_COUNT_WIDTH-1:0] rsp_entry_count,
   input logic                       rsp_last_entry
);

   // An accepted transaction either keeps the block busy or answers at once
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted transaction neither in progress nor answered");

   // Clear answers in the next cycle without going busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == OP_CLEAR)) |=> (rsp_strobe && !busy))
      else $error("clear not answered in one cycle");

   // A response is never shown while a transaction is still in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while busy");

   // A returned entry always carries a nonzero count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_valid_res) |-> (rsp_entry_count != '0))
      else $error("returned entry with zero count");

   // Empty responses carry all-zero fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_valid_res) |->
         ((rsp_entry_symbol == '0) && (rsp_entry_count == '0) && !rsp_last_entry))
      else $error("empty response with nonzero fields");

endmodule

bind byte_frequency_sorted_table bfst_checker u_bfst_checker (.*);
